/* rtl/tfhp_pkg.sv */
// Shared types and constants for the tunnel fragment header parser.
// Used by tfhp_step and by tunnel_fragment_header_parser_core; depends on nothing.
package tfhp_pkg;

    // Block geometry.
    localparam int BLOCK_BYTES = 1008;
    localparam int HASH_BYTES  = 32;
    localparam int POS_W       = 10;
    localparam int CNT_W       = 6;

    // Flag byte bits.
    localparam int FLAG_FOLLOW_BIT = 7;
    localparam int FLAG_FRAGD_BIT  = 3;
    localparam int FLAG_LAST_BIT   = 0;

    // Delivery type codes.
    localparam logic [1:0] DELIV_LOCAL  = 2'd0;
    localparam logic [1:0] DELIV_TUNNEL = 2'd1;
    localparam logic [1:0] DELIV_ROUTER = 2'd2;

    typedef enum logic [2:0] {
        ST_CHK     = 3'd0,
        ST_PAD     = 3'd1,
        ST_FLAG    = 3'd2,
        ST_TID     = 3'd3,
        ST_HASH    = 3'd4,
        ST_MSGID   = 3'd5,
        ST_SIZE    = 3'd6,
        ST_PAYLOAD = 3'd7
    } t_state;

    typedef enum logic [3:0] {
        KIND_CHECKSUM    = 4'd0,
        KIND_PADDING     = 4'd1,
        KIND_DELIMITER   = 4'd2,
        KIND_FLAG        = 4'd3,
        KIND_DEST_TUNNEL = 4'd4,
        KIND_HASH        = 4'd5,
        KIND_MSG_ID      = 4'd6,
        KIND_SIZE        = 4'd7,
        KIND_PAYLOAD     = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        ACT_DELIVER     = 3'd0,
        ACT_START       = 3'd1,
        ACT_FOLLOW_MID  = 3'd2,
        ACT_FOLLOW_LAST = 3'd3,
        ACT_NO_MSG_ID   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        STAT_MID       = 2'd0,
        STAT_OK        = 2'd1,
        STAT_NO_ZERO   = 2'd2,
        STAT_TRUNCATED = 2'd3
    } t_status;

    // Parser context carried from byte to byte.
    typedef struct packed {
        t_state            state;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  cnt;
        logic [31:0]       tid;
        logic [31:0]       mid;
        logic [15:0]       rem;
        logic [7:0]        flags;
    } t_ctx;

    // One tagged byte with its header report.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic        header_done;
        logic [1:0]  deliv_mode;
        logic [31:0] dest_tunnel;
        logic [31:0] message_id;
        logic [5:0]  fragment_number;
        t_action     action;
        logic [15:0] payload_size;
        logic        payload_last;
        t_status     block_status;
    } t_result;

endpackage

/* rtl/tfhp_step.sv */
// Next-context and result logic for one block byte.
// Depends on tfhp_pkg.
module tfhp_step (
    input  tfhp_pkg::t_ctx    i_ctx,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_of_block,
    output tfhp_pkg::t_ctx    o_ctx,
    output tfhp_pkg::t_result o_res
);
    import tfhp_pkg::*;

    t_ctx             ctx;
    t_result          res;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      rem_n;
    logic [1:0]       dt;
    t_state           st_after_hash;

    always_comb begin
        ctx = i_ctx;
        if (i_start_of_block) begin
            ctx.state = ST_CHK;
            ctx.pos   = '0;
            ctx.cnt   = '0;
        end
        pos           = ctx.pos;
        cnt_inc       = ctx.cnt + CNT_W'(1);
        rem_n         = '0;
        dt            = '0;
        st_after_hash = ctx.flags[FLAG_FRAGD_BIT] ? ST_MSGID : ST_SIZE;
        res           = '0;
        res.byte_value = i_data_byte;

        case (ctx.state)
            ST_PAD: begin
                if (i_data_byte == 8'd0) begin
                    res.kind  = KIND_DELIMITER;
                    ctx.state = ST_FLAG;
                end else begin
                    res.kind = KIND_PADDING;
                end
            end
            ST_FLAG: begin
                res.kind  = KIND_FLAG;
                ctx.flags = i_data_byte;
                ctx.tid   = '0;
                ctx.mid   = '0;
                ctx.rem   = '0;
                ctx.cnt   = '0;
                dt        = i_data_byte[6:5];
                if (i_data_byte[FLAG_FOLLOW_BIT]) begin
                    ctx.state = ST_MSGID;
                end else if (dt == DELIV_TUNNEL) begin
                    ctx.state = ST_TID;
                end else if (dt == DELIV_ROUTER) begin
                    ctx.state = ST_HASH;
                end else begin
                    ctx.state = i_data_byte[FLAG_FRAGD_BIT] ? ST_MSGID : ST_SIZE;
                end
            end
            ST_TID: begin
                res.kind = KIND_DEST_TUNNEL;
                ctx.tid  = {ctx.tid[23:0], i_data_byte};
                ctx.cnt  = cnt_inc;
                if (cnt_inc >= CNT_W'(4)) begin
                    ctx.cnt   = '0;
                    ctx.state = ST_HASH;
                end
            end
            ST_HASH: begin
                res.kind = KIND_HASH;
                ctx.cnt  = cnt_inc;
                if (cnt_inc >= CNT_W'(HASH_BYTES)) begin
                    ctx.cnt   = '0;
                    ctx.state = st_after_hash;
                end
            end
            ST_MSGID: begin
                res.kind = KIND_MSG_ID;
                ctx.mid  = {ctx.mid[23:0], i_data_byte};
                ctx.cnt  = cnt_inc;
                if (cnt_inc >= CNT_W'(4)) begin
                    ctx.cnt   = '0;
                    ctx.state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                res.kind = KIND_SIZE;
                rem_n    = {ctx.rem[7:0], i_data_byte};
                ctx.rem  = rem_n;
                ctx.cnt  = cnt_inc;
                if (cnt_inc >= CNT_W'(2)) begin
                    ctx.cnt          = '0;
                    res.header_done  = 1'b1;
                    res.payload_size = rem_n;
                    if (ctx.flags[FLAG_FOLLOW_BIT]) begin
                        res.message_id      = ctx.mid;
                        res.fragment_number = ctx.flags[6:1];
                        if (ctx.mid == 32'd0) begin
                            res.action = ACT_NO_MSG_ID;
                        end else begin
                            res.action = ctx.flags[FLAG_LAST_BIT] ? ACT_FOLLOW_LAST
                                                                  : ACT_FOLLOW_MID;
                        end
                    end else begin
                        res.deliv_mode = ctx.flags[6:5];
                        if (ctx.flags[6:5] == DELIV_TUNNEL) begin
                            res.dest_tunnel = ctx.tid;
                        end
                        if (ctx.flags[FLAG_FRAGD_BIT]) begin
                            res.message_id = ctx.mid;
                            res.action = (ctx.mid == 32'd0) ? ACT_NO_MSG_ID : ACT_START;
                        end else begin
                            res.action = ACT_DELIVER;
                        end
                    end
                    ctx.state = (rem_n != 16'd0) ? ST_PAYLOAD : ST_FLAG;
                end
            end
            ST_PAYLOAD: begin
                res.kind = KIND_PAYLOAD;
                rem_n    = ctx.rem - 16'd1;
                ctx.rem  = rem_n;
                if (rem_n == 16'd0) begin
                    res.payload_last = 1'b1;
                    ctx.state        = ST_FLAG;
                end
            end
            default: begin
                res.kind  = KIND_CHECKSUM;
                ctx.state = (pos >= POS_W'(3)) ? ST_PAD : ST_CHK;
            end
        endcase

        // The last byte of the block reports how the block ended.
        if (pos >= POS_W'(BLOCK_BYTES - 1)) begin
            if (ctx.state == ST_PAD) begin
                res.block_status = STAT_NO_ZERO;
            end else if (ctx.state == ST_FLAG) begin
                res.block_status = STAT_OK;
            end else begin
                res.block_status = STAT_TRUNCATED;
            end
            ctx.state = ST_CHK;
            ctx.pos   = '0;
            ctx.cnt   = '0;
        end else begin
            ctx.pos = pos + POS_W'(1);
        end

        o_ctx = ctx;
        o_res = res;
    end

endmodule

/* rtl/tunnel_fragment_header_parser_core.sv */
// Top level of the tunnel fragment header parser: handshakes, input and result registers.
// Depends on tfhp_pkg and tfhp_step.

// The parser takes a decrypted tunnel data block one byte per transaction and returns
// exactly one result transaction per byte, tagging the byte with its role (checksum,
// padding, delimiter, flag, tunnel id, hash, message id, size or payload). On the second
// size byte of each fragment it reports the parsed header and a reassembly action; on
// the last byte of a block it reports whether the block ended cleanly, never found the
// zero delimiter, or cut a fragment off. The block is BLOCK_BYTES long, and the parser
// returns to the checksum position on its own after the last byte; start_of_block
// forces a byte to be position zero and abandons any partial parse. Throughput is one
// byte per clock cycle while the consumer keeps up: a byte is captured in the input
// register, then the per-byte parse logic updates the context and writes the result
// register. The input side keeps accepting while a result waits, as long as the result
// register is being drained or is empty, so back-to-back bytes never stall unless the
// consumer does.
module tunnel_fragment_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic        o_header_done,
    output logic [1:0]  o_deliv_mode,
    output logic [31:0] o_dest_tunnel,
    output logic [31:0] o_message_id,
    output logic [5:0]  o_fragment_number,
    output logic [2:0]  o_action,
    output logic [15:0] o_payload_size,
    output logic        o_payload_last,
    output logic [1:0]  o_block_status
);
    import tfhp_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_sob;

    // Parser context and result register.
    t_ctx    r_ctx;
    t_ctx    n_ctx;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;

    // The captured byte moves forward when the result register is free or draining.
    logic w_adv;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    tfhp_step u_step (
        .i_ctx            (r_ctx),
        .i_data_byte      (r_in_byte),
        .i_start_of_block (r_in_sob),
        .o_ctx            (n_ctx),
        .o_res            (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_sob  <= i_start_of_block;
        end
    end

    // The context is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx       <= '{state: ST_CHK, default: '0};
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_ctx       <= n_ctx;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_res.kind;
    assign o_byte_value      = r_res.byte_value;
    assign o_header_done     = r_res.header_done;
    assign o_deliv_mode      = r_res.deliv_mode;
    assign o_dest_tunnel     = r_res.dest_tunnel;
    assign o_message_id      = r_res.message_id;
    assign o_fragment_number = r_res.fragment_number;
    assign o_action          = r_res.action;
    assign o_payload_size    = r_res.payload_size;
    assign o_payload_last    = r_res.payload_last;
    assign o_block_status    = r_res.block_status;

    // Header fields stay zero on every byte that does not complete a header.
    a_hdr_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_header_done) |->
        (o_action == ACT_DELIVER && o_payload_size == 16'd0 &&
         o_message_id == 32'd0 && o_dest_tunnel == 32'd0))
        else $error("header fields set without header_done");

    // Only a payload byte can close a fragment's payload.
    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_last) |-> (o_kind == KIND_PAYLOAD))
        else $error("payload_last on a non-payload byte");

    // A block end report returns the parser to the checksum position.
    a_block_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_res.block_status != STAT_MID) |=>
        (r_ctx.state == ST_CHK && r_ctx.pos == '0))
        else $error("parser did not rewind after block end");

    // The block position never reaches the block length.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctx.pos < POS_W'(BLOCK_BYTES))
        else $error("block position out of range");

    // An empty result register never holds back the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule
